FILE: rtl/swpm_pkg.sv
// ----------------------------------------------------------------------------
// swpm_pkg: shared constants for the sinc wave pixel map
// Fixed-point constants for angle reduction, the sine series and the word
// layout of the streaming ports.
// ----------------------------------------------------------------------------
package swpm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_CH        = 4;
  localparam int WORD_W        = 32;

  // 2^32 / (2*pi), one turn per radian in Q0.32.
  localparam logic [30:0] TURN_PER_RAD = 31'd683565276;
  // pi/2 and one in Q30.
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;

  // Horner steps of the sine series and their divisors.
  localparam int HRN_STEPS = 5;
  localparam int RECIP_SH  = 35;
  localparam logic [6:0] HRN_DIV [HRN_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [32:0] HRN_RECIP [HRN_STEPS] = '{
    33'((64'd1 << RECIP_SH) / 110),
    33'((64'd1 << RECIP_SH) / 72),
    33'((64'd1 << RECIP_SH) / 42),
    33'((64'd1 << RECIP_SH) / 20),
    33'((64'd1 << RECIP_SH) / 6)
  };

  // Angle, fold, square, three stages per Horner step, final product.
  localparam int SINE_LAT = 4 + 3 * HRN_STEPS;

  // Register index of the mode register.
  localparam logic REG_EQUAL_MODE = 1'b0;

endpackage

FILE: rtl/swpm_sine.sv
// ----------------------------------------------------------------------------
// swpm_sine: pipelined sine of (value + phase) in signed Q30
// Reduces the angle to one turn, folds it into the first quadrant and
// evaluates the series by Horner steps, one stage per multiply.
// ----------------------------------------------------------------------------
module swpm_sine #(
  parameter int FRAC_BITS = swpm_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] chan_i,
  input  logic signed [31:0] phase_i,
  output logic signed [31:0] sine_o
);
  import swpm_pkg::*;

  localparam int NSTG = 3 * HRN_STEPS;

  typedef struct packed {
    logic [31:0] x2;
    logic [30:0] x;
    logic [1:0]  quad;
  } hrn_carry_t;

  logic signed [32:0] angle;
  logic signed [64:0] t_full;
  logic [31:0]        turn_r;
  logic [30:0]        rmag;
  logic [61:0]        xprod;
  logic [30:0]        x_r;
  logic [1:0]         quad_r;
  logic [61:0]        sq;
  hrn_carry_t         cr_r [NSTG+1];
  logic [31:0]        n_a_r [HRN_STEPS];
  logic [31:0]        n_b_r [HRN_STEPS];
  logic [29:0]        est_r [HRN_STEPS];
  logic [30:0]        hh_r  [HRN_STEPS];
  logic [61:0]        fp;
  logic [31:0]        sine_r;
  logic [31:0]        sine_nxt;

  assign angle  = 33'(chan_i) + 33'(phase_i);
  assign t_full = angle * $signed({1'b0, TURN_PER_RAD});

  // Odd quadrants run backwards from a quarter turn.
  assign rmag  = turn_r[30] ? (ONE_Q30 - {1'b0, turn_r[29:0]}) : {1'b0, turn_r[29:0]};
  assign xprod = rmag * HALF_PI_Q30;
  assign sq    = x_r * x_r;

  always_ff @(posedge clk) begin
    if (en) begin
      turn_r   <= t_full[FRAC_BITS+31:FRAC_BITS];
      x_r      <= xprod[60:30];
      quad_r   <= turn_r[31:30];
      cr_r[0]  <= '{x2: sq[61:30], x: x_r, quad: quad_r};
    end
  end

  for (genvar i = 0; i < HRN_STEPS; i++) begin : g_hrn
    logic [30:0] h_in;
    logic [62:0] pa;
    logic [64:0] pb;
    logic [36:0] ek;
    logic [31:0] rm;
    logic [29:0] qd;

    if (i == 0) begin : g_first
      assign h_in = ONE_Q30;
    end else begin : g_next
      assign h_in = hh_r[i-1];
    end

    assign pa = cr_r[3*i].x2 * h_in;
    assign pb = n_a_r[i] * HRN_RECIP[i];
    // The reciprocal estimate is at most one low; one compare corrects it.
    assign ek = est_r[i] * HRN_DIV[i];
    assign rm = n_b_r[i] - ek[31:0];
    assign qd = est_r[i] + 30'(rm >= 32'(HRN_DIV[i]));

    always_ff @(posedge clk) begin
      if (en) begin
        n_a_r[i]     <= pa[61:30];
        cr_r[3*i+1]  <= cr_r[3*i];
        n_b_r[i]     <= n_a_r[i];
        est_r[i]     <= pb[64:RECIP_SH];
        cr_r[3*i+2]  <= cr_r[3*i+1];
        hh_r[i]      <= ONE_Q30 - 31'(qd);
        cr_r[3*i+3]  <= cr_r[3*i+2];
      end
    end
  end

  assign fp       = cr_r[NSTG].x * hh_r[HRN_STEPS-1];
  assign sine_nxt = cr_r[NSTG].quad[1] ? (32'd0 - {1'b0, fp[60:30]}) : {1'b0, fp[60:30]};

  always_ff @(posedge clk) begin
    if (en) begin
      sine_r <= sine_nxt;
    end
  end

  assign sine_o = $signed(sine_r);

endmodule

FILE: rtl/swpm_div.sv
// ----------------------------------------------------------------------------
// swpm_div: pipelined signed division of the sine by the channel value
// Restoring division on magnitudes, one quotient bit per stage, with the
// sign applied at the end. A zero value passes the sine through.
// ----------------------------------------------------------------------------
module swpm_div #(
  parameter int FRAC_BITS = swpm_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [31:0]         sine_i,
  input  logic signed [31:0]         chan_i,
  output logic signed [31+FRAC_BITS:0] r30_o
);
  import swpm_pkg::*;

  localparam int NW = 31 + FRAC_BITS;

  logic [31:0]    sneg;
  logic [30:0]    smag;
  logic [31:0]    vmag;
  logic [NW-1:0]  nq0;
  logic [31:0]    d0;
  logic           neg0;
  logic [31:0]    rem_r [NW+1];
  logic [NW-1:0]  nq_r  [NW+1];
  logic [31:0]    d_r   [NW+1];
  logic           neg_r [NW+1];
  logic [NW:0]    r30_r;

  assign sneg = 32'd0 - sine_i;
  assign smag = sine_i[31] ? sneg[30:0] : sine_i[30:0];
  assign vmag = chan_i[31] ? (32'd0 - chan_i) : chan_i;

  // With a zero value the sine itself is the quotient: divide it by one.
  always_comb begin
    if (chan_i == 32'sd0) begin
      nq0  = NW'(smag);
      d0   = 32'd1;
      neg0 = sine_i[31];
    end else begin
      nq0  = {smag, {FRAC_BITS{1'b0}}};
      d0   = vmag;
      neg0 = sine_i[31] ^ chan_i[31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= 32'd0;
      nq_r[0]  <= nq0;
      d_r[0]   <= d0;
      neg_r[0] <= neg0;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_bit
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_r[k], nq_r[k][NW-1]};
    assign diff  = trial - {1'b0, d_r[k]};
    assign ge    = trial >= {1'b0, d_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[31:0] : trial[31:0];
        nq_r[k+1]  <= {nq_r[k][NW-2:0], ge};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r30_r <= neg_r[NW] ? ((NW+1)'(0) - {1'b0, nq_r[NW]}) : {1'b0, nq_r[NW]};
    end
  end

  assign r30_o = $signed(r30_r);

endmodule

FILE: rtl/swpm_lane.sv
// ----------------------------------------------------------------------------
// swpm_lane: one channel of the pixel map
// Sine of value plus phase, division by the value, then halving, offset by
// one half, rounding and saturation to a signed 32-bit word.
// ----------------------------------------------------------------------------
module swpm_lane #(
  parameter int FRAC_BITS = swpm_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] chan_i,
  input  logic signed [31:0] phase_i,
  output logic signed [31:0] res_o
);
  import swpm_pkg::*;

  localparam int NW = 31 + FRAC_BITS;
  localparam logic signed [NW+1:0] RND  = (NW+2)'((64'd1 << 30) + (64'd1 << (30 - FRAC_BITS)));
  localparam logic signed [NW+1:0] YMAX = $signed({{(NW-29){1'b0}}, 31'h7fff_ffff});
  localparam logic signed [NW+1:0] YMIN = $signed({{(NW-29){1'b1}}, 31'h0});

  logic signed [31:0] sine;
  logic signed [31:0] dly_r [SINE_LAT];
  logic signed [NW:0] r30;
  logic signed [NW+1:0] y_full;
  logic signed [NW+1:0] y_sh;
  logic [31:0]        y_nxt;
  logic [31:0]        y_r;

  swpm_sine #(.FRAC_BITS(FRAC_BITS)) u_sine (
    .clk     (clk),
    .en      (en),
    .chan_i  (chan_i),
    .phase_i (phase_i),
    .sine_o  (sine)
  );

  // The value waits beside the sine pipeline for the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= chan_i;
      for (int k = 1; k < SINE_LAT; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  swpm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .en     (en),
    .sine_i (sine),
    .chan_i (dly_r[SINE_LAT-1]),
    .r30_o  (r30)
  );

  assign y_full = (NW+2)'(r30) + RND;
  assign y_sh   = y_full >>> (31 - FRAC_BITS);

  always_comb begin
    if (y_sh > YMAX) begin
      y_nxt = 32'h7fff_ffff;
    end else if (y_sh < YMIN) begin
      y_nxt = 32'h8000_0000;
    end else begin
      y_nxt = y_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

  assign res_o = $signed(y_r);

endmodule

FILE: rtl/sinc_wave_pixel_map_core.sv
// ----------------------------------------------------------------------------
// sinc_wave_pixel_map_core: shifted sinc per pixel channel, halved and offset
// The latency is set by the sine pipeline and the one-bit-per-stage
// divider. Throughput is one word per cycle; a stall on the output holds
// the whole pipeline.
// Reset clears the valid bits and the mode register; payload is not reset.
// ----------------------------------------------------------------------------
module sinc_wave_pixel_map_core #(
  parameter int FRAC_BITS = swpm_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // chan_x, chan_y, chan_z, chan_alpha, phase_x, phase_y, phase_z, phase_alpha
  input  logic [255:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_x, out_y, out_z, out_alpha
  output logic [127:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import swpm_pkg::*;

  localparam int LAT = SINE_LAT + 31 + FRAC_BITS + 3;

  logic               en;
  logic [LAT-1:0]     vld_r;
  logic [LAT-1:0]     vld_nxt;
  logic               equal_mode_r;
  logic               equal_mode_nxt;
  logic signed [31:0] chan  [NUM_CH];
  logic signed [31:0] phase [NUM_CH];
  logic signed [31:0] res   [NUM_CH];

  assign en        = out_tready | ~vld_r[LAT-1];
  assign in_tready = en;

  // Equal mode puts only the alpha result, with the second phase, on every field.
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic signed [31:0] ph_sel;

    assign chan[c]  = $signed(in_tdata[WORD_W*c +: WORD_W]);
    assign phase[c] = $signed(in_tdata[WORD_W*(NUM_CH+c) +: WORD_W]);

    if (c == NUM_CH - 1) begin : g_alpha
      assign ph_sel = equal_mode_r ? phase[1] : phase[c];
    end else begin : g_other
      assign ph_sel = phase[c];
    end

    swpm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .en      (en),
      .chan_i  (chan[c]),
      .phase_i (ph_sel),
      .res_o   (res[c])
    );

    assign out_tdata[WORD_W*c +: WORD_W] = equal_mode_r ? res[NUM_CH-1] : res[c];
  end

  assign vld_nxt = en ? {vld_r[LAT-2:0], in_tvalid} : vld_r;
  assign out_tvalid = vld_r[LAT-1];

  always_comb begin
    equal_mode_nxt = equal_mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_EQUAL_MODE)) begin
      equal_mode_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      equal_mode_r <= 1'b0;
    end else begin
      vld_r        <= vld_nxt;
      equal_mode_r <= equal_mode_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_EQUAL_MODE) ? {31'd0, equal_mode_r} : 32'd0;

endmodule

FILE: dv/sinc_wave_pixel_map_core_tb.sv
// ----------------------------------------------------------------------------
// sinc_wave_pixel_map_core_tb: self-checking bench for the sinc pixel map
// Streams pixels through the core under both mode settings and several idling
// patterns, predicts each result word in fixed point and compares per field.
// ----------------------------------------------------------------------------
module sinc_wave_pixel_map_core_tb;
  import swpm_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LAT = 53 + FB;
  localparam longint LIMIT = 2000000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [255:0] in_tdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] out_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  sinc_wave_pixel_map_core #(.FRAC_BITS(FB)) DUT (.*);

  always #10 clk = ~clk;

  logic [255:0] pixel_q[$];
  int  send_idle = 0, recv_stall = 0;
  int  fails = 0, words_in = 0, words_out = 0;
  logic mode = 1'b0;
  longint cycles = 0;

  // Polynomial sine of a 33-bit angle in Q16.16 radians, answered in Q30.
  function automatic longint sine_of(longint ang);
    longint t;
    logic [63:0] tu;
    logic [31:0] u;
    logic [1:0]  q;
    longint r, x, x2, h;
    int divs[5];
    divs = '{110, 72, 42, 20, 6};
    t = ang * 64'sd683565276;
    tu = t;
    u = tu >> FB;
    q = u[31:30];
    r = u[29:0];
    if (q[0]) r = (64'sd1 << 30) - r;
    x = (r * 64'sd1686629713) >>> 30;
    x2 = (x * x) >>> 30;
    h = 64'sd1 << 30;
    for (int k = 0; k < 5; k++) h = (64'sd1 << 30) - ((x2 * h) >>> 30) / divs[k];
    h = (x * h) >>> 30;
    return q[1] ? -h : h;
  endfunction

  function automatic logic [31:0] sinc_half(logic signed [31:0] v, logic signed [31:0] p);
    longint s, r, y;
    s = sine_of(longint'(v) + longint'(p));
    r = (v != 0) ? (s * (64'sd1 << FB)) / longint'(v) : s;
    y = (r + (64'sd1 << 30) + (64'sd1 << (30 - FB))) >>> (31 - FB);
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    return y[31:0];
  endfunction

  function automatic logic [127:0] pixel_map(logic [255:0] d, logic eq);
    logic [31:0] a;
    if (eq) begin
      a = sinc_half(d[127:96], d[191:160]);
      return {a, a, a, a};
    end
    return {sinc_half(d[127:96], d[255:224]), sinc_half(d[95:64], d[223:192]),
            sinc_half(d[63:32], d[191:160]), sinc_half(d[31:0], d[159:128])};
  endfunction

  // Driver: one word per accepted handshake, gaps drawn per cycle.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) words_in <= words_in + 1;
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_tdata <= pixel_q.pop_front();
          in_tvalid <= 1'b1;
        end else in_tvalid <= 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  logic [255:0] exp_in_q[$];
  // Monitor: checks every accepted result against the oldest prediction.
  always @(posedge clk) begin
    logic [127:0] e;
    if (rst_n && in_tvalid && in_tready) exp_in_q.push_back(pixel_map(in_tdata, mode));
    if (rst_n && out_tvalid && out_tready) begin
      words_out <= words_out + 1;
      if (exp_in_q.size() == 0) begin
        $display("%0t expected no word actual %h", $time, out_tdata);
        fails = fails + 1;
      end else begin
        e = exp_in_q.pop_front();
        for (int i = 0; i < 4; i++)
          if (e[32*i +: 32] !== out_tdata[32*i +: 32]) begin
            $display("%0t field %0d expected %h actual %h", $time, i, e[32*i +: 32],
                     out_tdata[32*i +: 32]);
            fails = fails + 1;
          end
      end
    end
  end

  task automatic write_mode(logic val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {REG_EQUAL_MODE, 2'b00}; cfg_pwdata <= {$urandom} & ~32'h1 | val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    mode <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || in_tvalid || exp_in_q.size() > 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(8)) - 4);
      3: return {{14{$urandom_range(1) == 1}}, 18'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic load_random(int n);
    logic [255:0] d;
    for (int i = 0; i < n; i++) begin
      for (int f = 0; f < 8; f++) d[32*f +: 32] = rand_word();
      if ($urandom_range(7) == 0) d[32*$urandom_range(3) +: 32] = '0;
      pixel_q.push_back(d);
    end
  endtask

  initial begin
    int idle_s[4], idle_r[4];
    logic [31:0] ext[6];
    idle_s = '{0, 87, 0, 17};
    idle_r = '{0, 0, 87, 17};
    ext = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff, 32'h0001_0000};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);
    // Directed: extreme values, zero channels, small values that saturate.
    for (int i = 0; i < 12; i++)
      pixel_q.push_back({ext[i % 6], ext[(i + 1) % 6], ext[(i + 2) % 6], ext[(i + 3) % 6],
                         ext[(i + 4) % 6], ext[(i + 5) % 6], ext[i % 6], ext[(i + 2) % 6]});
    drain();
    write_mode(1'b1);
    for (int i = 0; i < 8; i++)
      pixel_q.push_back({ext[i % 6], ext[(i + 3) % 6], ext[(i + 1) % 6], ext[(i + 4) % 6],
                         ext[(i + 2) % 6], ext[(i + 5) % 6], ext[i % 6], ext[(i + 1) % 6]});
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph[0]);
      send_idle = idle_s[ph % 4];
      recv_stall = idle_r[ph % 4];
      load_random(250);
      drain();
    end
    send_idle = 0; recv_stall = 0;
    $display("Sent %0d words and checked %0d results across both modes and four idling patterns.",
             words_in, words_out);
    if (fails == 0) $display("sinc_wave_pixel_map_core_tb OK");
    else $display("sinc_wave_pixel_map_core_tb NOT OK");
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("sinc_wave_pixel_map_core_tb NOT OK");
    $finish;
  end

endmodule
